FILE: sv/bdlp_pkg.sv
// Shared types, codes and reset constants for the button debounce and long press block.
package bdlp_pkg;

	localparam int NUM_BUTTONS_DEFAULT = 3;
	localparam int PIN_COUNT           = 3;
	localparam int TIME_W              = 16;
	localparam int TICK_W              = 32;
	localparam int CFG_INDEX_W         = 2;

	localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 16'd30;
	localparam logic [TIME_W-1:0] LONG_RESET     = 16'd1000;
	localparam logic [TIME_W-1:0] REPEAT_RESET   = 16'd200;

	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LONG     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_REPEAT   = 2'd2;

	typedef enum logic [1:0] {
		MODE_IDLE     = 2'd0,
		MODE_DEBOUNCE = 2'd1,
		MODE_PRESSED  = 2'd2,
		MODE_LONG     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_SHORT = 2'd1,
		EV_LONG  = 2'd2,
		EV_HOLD  = 2'd3
	} event_t;

	typedef struct packed {
		logic [TIME_W-1:0] debounce_time;
		logic [TIME_W-1:0] long_press_time;
		logic [TIME_W-1:0] repeat_interval;
	} cfg_t;

endpackage

FILE: sv/bdlp_if.sv
// Valid/ready channel interfaces for request and event items.
interface bdlp_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [2:0]  pressed_bits;
	logic [31:0] tick_now;
	logic [1:0]  button_index;

	modport source (output valid, output opcode, output pressed_bits, output tick_now,
		output button_index, input ready);
	modport sink (input valid, input opcode, input pressed_bits, input tick_now,
		input button_index, output ready);
endinterface

interface bdlp_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_code;

	modport source (output valid, output event_code, input ready);
	modport sink (input valid, input event_code, output ready);
endinterface

FILE: sv/bdlp_cell.sv
// Per-button debounce, long press and repeat state machine with its pending event.
module bdlp_cell
	import bdlp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              scan_en,
	input  logic              down,
	input  logic [TICK_W-1:0] now,
	input  logic              clear_en,
	output event_t            pending
);

	mode_t             mode_q, mode_d;
	logic [TICK_W-1:0] press_stamp_q, press_stamp_d;
	logic [TICK_W-1:0] repeat_stamp_q, repeat_stamp_d;
	event_t            pending_q, pending_d;
	logic [TICK_W-1:0] elapsed;
	logic [TIME_W-1:0] limit;
	logic              expired;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_IDLE;
			press_stamp_q  <= '0;
			repeat_stamp_q <= '0;
			pending_q      <= EV_NONE;
		end else begin
			mode_q         <= mode_d;
			press_stamp_q  <= press_stamp_d;
			repeat_stamp_q <= repeat_stamp_d;
			pending_q      <= pending_d;
		end
	end

	always_comb begin
		elapsed = now - ((mode_q == MODE_LONG) ? repeat_stamp_q : press_stamp_q);
		unique case (mode_q)
			MODE_DEBOUNCE: limit = cfg.debounce_time;
			MODE_PRESSED:  limit = cfg.long_press_time;
			default:       limit = cfg.repeat_interval;
		endcase
		expired = elapsed >= {{(TICK_W-TIME_W){1'b0}}, limit};

		mode_d         = mode_q;
		press_stamp_d  = press_stamp_q;
		repeat_stamp_d = repeat_stamp_q;
		pending_d      = clear_en ? EV_NONE : pending_q;

		if (scan_en) begin
			unique case (mode_q)
				MODE_IDLE: begin
					if (down) begin
						mode_d        = MODE_DEBOUNCE;
						press_stamp_d = now;
					end
				end
				MODE_DEBOUNCE: begin
					if (!down) begin
						mode_d = MODE_IDLE;
					end else if (expired) begin
						mode_d        = MODE_PRESSED;
						pending_d     = EV_SHORT;
						press_stamp_d = now;
					end
				end
				MODE_PRESSED: begin
					if (!down) begin
						mode_d = MODE_IDLE;
					end else if (expired) begin
						mode_d         = MODE_LONG;
						pending_d      = EV_LONG;
						repeat_stamp_d = now;
					end
				end
				MODE_LONG: begin
					if (!down) begin
						mode_d = MODE_IDLE;
					end else if (expired) begin
						pending_d      = EV_HOLD;
						repeat_stamp_d = now;
					end
				end
			endcase
		end
	end

	assign pending = pending_q;

endmodule

FILE: sv/button_debounce_long_press_unit.sv
// Top level of the button debounce and long press block with its request and event channels.
//
// Requests arrive on req as valid/ready items. A scan item (opcode 0) carries one pressed
// bit per button and the millisecond tick; it updates every button's state machine and
// returns nothing. A read item (opcode 1) returns the pending event of button_index on
// rsp and clears it; a read of a button that does not exist returns no event.
// The user writes thresholds via cfg_we, cfg_index, cfg_wdata only while idle; unchecked.
// An accepted item is held in an input register; from there the button cells update and
// a read result is loaded into the registered output that drives rsp.valid, unless the
// read must wait for the output register to free. Each button cell has a single subtract
// and compare; one item is taken every cycle unless a read waits in the input register.
// When rsp stalls, the output register holds the result and the input register still
// takes one more item; scans keep flowing, while a second read waits in the input
// register until the output register frees.
// Reset clears all buttons to idle with no pending event, empties both registers and
// loads the thresholds with 30, 1000 and 200 milliseconds.
module button_debounce_long_press_unit
	import bdlp_pkg::*;
#(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	bdlp_req_if.sink               req,
	bdlp_rsp_if.source             rsp,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]      cfg_wdata
);

	cfg_t              cfg_q;
	logic              valid_s1;
	logic              opcode_s1;
	logic [2:0]        pressed_s1;
	logic [TICK_W-1:0] tick_s1;
	logic [1:0]        index_s1;
	logic              fire_s1;
	logic              scan_en;
	logic              read_fire;
	logic              out_valid_q;
	event_t            event_q;
	event_t            read_event;
	event_t            pending [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] clear_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time   <= DEBOUNCE_RESET;
			cfg_q.long_press_time <= LONG_RESET;
			cfg_q.repeat_interval <= REPEAT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_time   <= cfg_wdata;
				REG_LONG:     cfg_q.long_press_time <= cfg_wdata;
				REG_REPEAT:   cfg_q.repeat_interval <= cfg_wdata;
				default:      cfg_q                 <= cfg_q;
			endcase
		end
	end

	assign fire_s1   = valid_s1 && (opcode_s1 == OP_SCAN || !out_valid_q || rsp.ready);
	assign scan_en   = fire_s1 && opcode_s1 == OP_SCAN;
	assign read_fire = fire_s1 && opcode_s1 == OP_READ;
	assign req.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			opcode_s1  <= req.opcode;
			pressed_s1 <= req.pressed_bits;
			tick_s1    <= req.tick_now;
			index_s1   <= req.button_index;
		end
	end

	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
		logic down;
		if (b < PIN_COUNT) begin : g_pin
			assign down = pressed_s1[b];
		end else begin : g_nopin
			assign down = 1'b0;
		end
		assign clear_vec[b] = read_fire && (int'(index_s1) == b);

		bdlp_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cfg      (cfg_q),
			.scan_en  (scan_en),
			.down     (down),
			.now      (tick_s1),
			.clear_en (clear_vec[b]),
			.pending  (pending[b])
		);
	end

	always_comb begin
		read_event = EV_NONE;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			if (int'(index_s1) == b) begin
				read_event = pending[b];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (read_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (read_fire) begin
			event_q <= read_event;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.event_code = event_q;

	a_read_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		read_fire |=> rsp.valid)
		else $error("Read item did not produce a result.");

	a_scan_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_en && !out_valid_q) |=> !rsp.valid)
		else $error("Scan item produced a result.");

	a_single_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(clear_vec))
		else $error("More than one button event cleared by one read.");

	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> req.ready)
		else $error("Empty input register refused an item.");

endmodule

FILE: bench/button_debounce_long_press_unit_test.sv
// Self-checking testbench for the button debounce and long press unit.
`timescale 1ns / 1ps

module button_debounce_long_press_unit_test;
	import bdlp_pkg::*;

	localparam int BUTTONS       = NUM_BUTTONS_DEFAULT;
	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_LIMIT   = 4000;
	localparam int PHASE_ITEMS   = 80;
	localparam int PHASE_COUNT   = 6;

	typedef struct packed {
		logic              opcode;
		logic [2:0]        pressed_bits;
		logic [TICK_W-1:0] tick_now;
		logic [1:0]        button_index;
	} request_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [TIME_W-1:0]      cfg_wdata;

	bdlp_req_if req_ch();
	bdlp_rsp_if rsp_ch();

	button_debounce_long_press_unit #(.NUM_BUTTONS(BUTTONS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	cfg_t              thresholds;
	mode_t             btn_mode     [BUTTONS];
	logic [TICK_W-1:0] press_tick   [BUTTONS];
	logic [TICK_W-1:0] repeat_tick  [BUTTONS];
	event_t            unread_event [BUTTONS];

	request_t pending_requests[$];
	event_t   expected_events[$];

	int                send_idle_pct;
	int                recv_idle_pct;
	logic              req_taken;
	int                stall_cycles;
	int                fail_count;
	int                scan_count;
	int                read_count;
	int                setting_count;
	logic [TICK_W-1:0] gen_tick;
	logic [2:0]        gen_bits;
	int                hold_left;
	request_t          next_req;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic update_button_model(input request_t rq);
		logic              down;
		logic [TICK_W-1:0] since_press;
		logic [TICK_W-1:0] since_repeat;
		if (rq.opcode == OP_SCAN) begin
			for (int b = 0; b < BUTTONS; b++) begin
				down = (b < PIN_COUNT) ? rq.pressed_bits[b] : 1'b0;
				since_press = rq.tick_now - press_tick[b];
				since_repeat = rq.tick_now - repeat_tick[b];
				case (btn_mode[b])
				MODE_IDLE: begin
					if (down) begin
						btn_mode[b] = MODE_DEBOUNCE;
						press_tick[b] = rq.tick_now;
					end
				end
				MODE_DEBOUNCE: begin
					if (!down) begin
						btn_mode[b] = MODE_IDLE;
					end else if (since_press >= thresholds.debounce_time) begin
						btn_mode[b] = MODE_PRESSED;
						unread_event[b] = EV_SHORT;
						press_tick[b] = rq.tick_now;
					end
				end
				MODE_PRESSED: begin
					if (!down) begin
						btn_mode[b] = MODE_IDLE;
					end else if (since_press >= thresholds.long_press_time) begin
						btn_mode[b] = MODE_LONG;
						unread_event[b] = EV_LONG;
						repeat_tick[b] = rq.tick_now;
					end
				end
				default: begin
					if (!down) begin
						btn_mode[b] = MODE_IDLE;
					end else if (since_repeat >= thresholds.repeat_interval) begin
						unread_event[b] = EV_HOLD;
						repeat_tick[b] = rq.tick_now;
					end
				end
				endcase
			end
		end else if (rq.button_index < BUTTONS) begin
			expected_events.push_back(unread_event[rq.button_index]);
			unread_event[rq.button_index] = EV_NONE;
		end else begin
			expected_events.push_back(EV_NONE);
		end
	endtask

	task automatic push_request(input logic op, input logic [2:0] bits,
		input logic [TICK_W-1:0] tick, input logic [1:0] idx);
		pending_requests.push_back({op, bits, tick, idx});
	endtask

	task automatic queue_traffic_item();
		request_t          rq;
		int                pick;
		int                span;
		logic [TICK_W-1:0] step;
		pick = $urandom_range(99);
		rq.opcode = OP_SCAN;
		rq.button_index = 2'($urandom_range(3));
		rq.pressed_bits = 3'($urandom_range(7));
		rq.tick_now = $urandom;
		if (pick < 30) begin
			rq.opcode = OP_READ;
		end else if (pick < 38) begin
			gen_tick = rq.tick_now;
		end else begin
			// A pin pattern is held over several scans so that presses can mature.
			if (hold_left == 0) begin
				gen_bits = 3'($urandom_range(7));
				hold_left = $urandom_range(12, 2);
			end
			hold_left--;
			span = int'(thresholds.debounce_time);
			if (int'(thresholds.long_press_time) > span) span = int'(thresholds.long_press_time);
			if (int'(thresholds.repeat_interval) > span) span = int'(thresholds.repeat_interval);
			case ($urandom_range(6))
			0: step = '0;
			1: step = 32'(thresholds.debounce_time);
			2: step = 32'(thresholds.long_press_time);
			3: step = 32'(thresholds.repeat_interval);
			4: step = 32'(thresholds.debounce_time) - 32'd1;
			5: step = 32'(thresholds.long_press_time) - 32'd1;
			default: step = $urandom_range(span / 2 + 1);
			endcase
			gen_tick = gen_tick + step;
			rq.pressed_bits = gen_bits;
			rq.tick_now = gen_tick;
		end
		pending_requests.push_back(rq);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [TIME_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
		REG_DEBOUNCE: thresholds.debounce_time = val;
		REG_LONG: thresholds.long_press_time = val;
		default: thresholds.repeat_interval = val;
		endcase
	endtask

	task automatic set_thresholds(input logic [TIME_W-1:0] dbt, input logic [TIME_W-1:0] lpt,
		input logic [TIME_W-1:0] rpt);
		write_reg(REG_DEBOUNCE, dbt);
		write_reg(REG_LONG, lpt);
		write_reg(REG_REPEAT, rpt);
		setting_count++;
	endtask

	task automatic drain();
		while (pending_requests.size() != 0 || req_ch.valid || expected_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_ch.valid || req_taken) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = pending_requests.pop_front();
					req_ch.valid        <= 1'b1;
					req_ch.opcode       <= next_req.opcode;
					req_ch.pressed_bits <= next_req.pressed_bits;
					req_ch.tick_now     <= next_req.tick_now;
					req_ch.button_index <= next_req.button_index;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			req_taken <= req_ch.valid && req_ch.ready;
			if (req_ch.valid && req_ch.ready) begin
				update_button_model({req_ch.opcode, req_ch.pressed_bits, req_ch.tick_now,
					req_ch.button_index});
				if (req_ch.opcode == OP_SCAN) scan_count++;
				else read_count++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_events.size() == 0) begin
					$error("event_code: expected no item, got %0d", rsp_ch.event_code);
					fail_count++;
				end else begin
					if (rsp_ch.event_code !== expected_events[0]) begin
						$error("event_code: expected %0d, got %0d", expected_events[0],
							rsp_ch.event_code);
						fail_count++;
					end
					void'(expected_events.pop_front());
				end
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles + 1 >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		logic [TICK_W-1:0] base;
		int                phase;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DEBOUNCE;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_SCAN;
		req_ch.pressed_bits = '0;
		req_ch.tick_now = '0;
		req_ch.button_index = '0;
		rsp_ch.ready = 1'b0;
		req_taken = 1'b0;
		stall_cycles = 0;
		fail_count = 0;
		scan_count = 0;
		read_count = 0;
		setting_count = 1;
		hold_left = 0;
		gen_bits = '0;
		gen_tick = '0;
		send_idle_pct = 24;
		recv_idle_pct = 55;
		thresholds = {DEBOUNCE_RESET, LONG_RESET, REPEAT_RESET};
		for (int b = 0; b < BUTTONS; b++) begin
			btn_mode[b] = MODE_IDLE;
			press_tick[b] = '0;
			repeat_tick[b] = '0;
			unread_event[b] = EV_NONE;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset thresholds; the press starts just below the tick wrap point.
		base = 32'hFFFF_FFF0;
		push_request(OP_READ, 3'b000, 32'd0, 2'd0);
		push_request(OP_READ, 3'b111, 32'hFFFF_FFFF, 2'd3);
		push_request(OP_SCAN, 3'b001, base, 2'd0);
		push_request(OP_SCAN, 3'b001, base + 29, 2'd1);
		push_request(OP_SCAN, 3'b001, base + 30, 2'd2);
		push_request(OP_READ, 3'b000, 32'd0, 2'd0);
		push_request(OP_READ, 3'b000, 32'd0, 2'd0);
		push_request(OP_SCAN, 3'b011, base + 1029, 2'd3);
		push_request(OP_SCAN, 3'b011, base + 1030, 2'd0);
		push_request(OP_READ, 3'b101, 32'h5555_5555, 2'd0);
		push_request(OP_SCAN, 3'b111, base + 1230, 2'd0);
		push_request(OP_SCAN, 3'b111, base + 1430, 2'd0);
		push_request(OP_READ, 3'b000, 32'd0, 2'd0);
		push_request(OP_READ, 3'b000, 32'd0, 2'd1);
		push_request(OP_READ, 3'b000, 32'd0, 2'd2);
		push_request(OP_SCAN, 3'b110, base + 1431, 2'd0);
		push_request(OP_SCAN, 3'b000, base + 1500, 2'd0);
		push_request(OP_READ, 3'b010, 32'hAAAA_AAAA, 2'd3);
		push_request(OP_READ, 3'b000, 32'd0, 2'd1);
		drain();

		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
			0: set_thresholds(16'd0, 16'd0, 16'd0);
			1: set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
			2: set_thresholds(16'($urandom_range(50)), 16'($urandom_range(50)),
				16'($urandom_range(50)));
			3: set_thresholds(16'd1, 16'hFFFF, 16'd0);
			4: set_thresholds(16'($urandom_range(65535)), 16'($urandom_range(65535)),
				16'($urandom_range(65535)));
			default: set_thresholds(DEBOUNCE_RESET, LONG_RESET, REPEAT_RESET);
			endcase
			if (phase == 2) begin
				send_idle_pct = 55;
				recv_idle_pct = 24;
			end else if (phase == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			gen_tick = (phase == 1) ? 32'hFFFF_0000 : $urandom;
			gen_bits = '0;
			hold_left = 0;
			repeat (PHASE_ITEMS) queue_traffic_item();
			drain();
		end

		$display("Run covered %0d scans and %0d reads over %0d threshold settings,",
			scan_count, read_count, setting_count);
		$display("including held and broken press patterns, tick wrap and stalls on both sides.");
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/bdlp_pkg.sv
sv/bdlp_if.sv
sv/bdlp_cell.sv
sv/button_debounce_long_press_unit.sv
bench/button_debounce_long_press_unit_test.sv
